// ===== rtl/wpel_pkg.sv =====
// Shared widths, codes and state types of the weighted pick block.
`timescale 1ns / 1ps
`default_nettype none

package wpel_pkg;

  localparam int KEY_W           = 16;
  localparam int WEIGHT_W        = 8;
  localparam int RAND_W          = 31;
  localparam int STATUS_W        = 2;
  localparam int PICK_W          = 6;
  localparam int MAX_ENTRIES_DEF = 64;

  // Request codes
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_DRAW   = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PICKED   = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_APPENDED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MOD,
    S_WALK,
    S_POST
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/wpel_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module wpel_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/wpel_mod.sv =====
// Bit-serial restoring remainder unit: num mod den, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module wpel_mod #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [DEN_W-1:0] rem
);

  localparam int CW = $clog2(NUM_W);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [NUM_W-1:0] shreg;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Shift in the next dividend bit and compare against the divisor
  always_comb begin
    trial = {rem, shreg[NUM_W-1]};
    ge    = trial >= {1'b0, den};
  end

  // Control: count down the dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= num;
    end else if (busy) begin
      rem   <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      shreg <= {shreg[NUM_W-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/weighted_pick_excluding_last.sv =====
// Top level of the weighted pick block: entry table, draw sequencer, result word.
`timescale 1ns / 1ps
`default_nettype none

// Weighted random pick over a table of (key, weight) entries held in one RAM,
// skipping every entry whose key equals the last winner's key. An append word
// writes the next free row and answers "appended", or "full" once MAX_ENTRIES
// rows are taken. A draw word on an empty table answers "empty". Otherwise the
// draw streams the table through the RAM read port once to sum eligible
// weights, reduces random_value mod the sum in a bit-serial remainder unit,
// then streams the table a second time to walk the wheel. A zero eligible sum
// picks row 0. One word is in work at a time; the result sits in an output
// register, and the block returns to accept the next word as soon as that
// register has taken it. Nothing is cleared in the RAM after reset: only rows
// below the entry count are ever read.
module weighted_pick_excluding_last #(
  parameter int MAX_ENTRIES = wpel_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          req_type,
  input  wire logic [wpel_pkg::KEY_W-1:0]    entry_key,
  input  wire logic [wpel_pkg::WEIGHT_W-1:0] entry_weight,
  input  wire logic [wpel_pkg::RAND_W-1:0]   random_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wpel_pkg::STATUS_W-1:0]      status,
  output logic [wpel_pkg::PICK_W-1:0]        picked_index,
  output logic [wpel_pkg::KEY_W-1:0]         picked_key
);

  localparam int KW    = wpel_pkg::KEY_W;
  localparam int WW    = wpel_pkg::WEIGHT_W;
  localparam int PW    = wpel_pkg::PICK_W;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = WW + IDX_W;
  localparam int RAM_W = KW + WW;

  wpel_pkg::state_t  state, state_next;

  logic [CNT_W-1:0]  count;
  logic [KW-1:0]     last_key;
  logic [CNT_W-1:0]  rd_addr;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [RAM_W-1:0]  rdata;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  remain;
  logic [KW-1:0]     key0;
  logic [wpel_pkg::RAND_W-1:0] rnd;

  wpel_pkg::status_t res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [KW-1:0]     res_key;

  logic              mod_start;
  logic              mod_done;
  logic [SUM_W-1:0]  mod_rem;

  logic              in_acc;
  logic              is_full;
  logic              is_append;
  logic [KW-1:0]     rd_key;
  logic [WW-1:0]     rd_wt;
  logic              eligible;
  logic              hit;
  logic              scan_end;
  logic              out_free;
  logic              issue;
  logic              ram_we;
  logic              load_out;

  // Decode handshake and the word streaming out of the RAM
  always_comb begin
    in_stall  = (state != wpel_pkg::S_IDLE);
    in_acc    = in_valid && !in_stall;
    is_append = (req_type == wpel_pkg::REQ_APPEND);
    is_full   = (count == CNT_W'(MAX_ENTRIES));
    rd_key    = rdata[RAM_W-1:WW];
    rd_wt     = rdata[WW-1:0];
    eligible  = rd_vld && (rd_key != last_key);
    hit       = eligible && (SUM_W'(rd_wt) >= remain);
    scan_end  = (rd_addr == count) && !rd_vld;
    out_free  = !out_valid || !out_stall;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      wpel_pkg::S_IDLE: begin
        if (in_acc) begin
          if (is_append || (count == '0)) begin
            state_next = wpel_pkg::S_POST;
          end else begin
            state_next = wpel_pkg::S_SUM;
          end
        end
      end
      wpel_pkg::S_SUM: begin
        if (scan_end) begin
          state_next = (sum == '0) ? wpel_pkg::S_POST : wpel_pkg::S_MOD;
        end
      end
      wpel_pkg::S_MOD: begin
        if (mod_done) begin
          state_next = wpel_pkg::S_WALK;
        end
      end
      wpel_pkg::S_WALK: begin
        if (hit || scan_end) begin
          state_next = wpel_pkg::S_POST;
        end
      end
      wpel_pkg::S_POST: begin
        if (out_free) begin
          state_next = wpel_pkg::S_IDLE;
        end
      end
      default: state_next = wpel_pkg::S_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    issue     = 1'b0;
    mod_start = 1'b0;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    unique case (state)
      wpel_pkg::S_IDLE: ram_we = in_acc && is_append && !is_full;
      wpel_pkg::S_SUM: begin
        issue     = (rd_addr != count);
        mod_start = scan_end && (sum != '0);
      end
      wpel_pkg::S_MOD:  ;
      wpel_pkg::S_WALK: issue = (rd_addr != count);
      wpel_pkg::S_POST: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wpel_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Entry table: key in the upper bits, weight in the lower
  wpel_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata ({entry_key, entry_weight}),
    .raddr (rd_addr[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Remainder of the random word by the eligible sum
  wpel_mod #(
    .NUM_W (wpel_pkg::RAND_W),
    .DEN_W (SUM_W)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .num   (rnd),
    .den   (sum),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // Control registers: fill count, last winner, read stream
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      last_key <= '0;
      rd_addr  <= '0;
      rd_vld   <= 1'b0;
    end else begin
      if (ram_we) begin
        count <= count + 1'b1;
      end
      if (state == wpel_pkg::S_SUM && scan_end && sum == '0) begin
        last_key <= key0;
      end else if (state == wpel_pkg::S_WALK && hit) begin
        last_key <= rd_key;
      end else if (state == wpel_pkg::S_WALK && scan_end) begin
        last_key <= key0;
      end
      // Rewind the read pointer before each pass, advance while streaming
      if (state == wpel_pkg::S_IDLE || (state == wpel_pkg::S_SUM && scan_end)) begin
        rd_addr <= '0;
      end else if (issue) begin
        rd_addr <= rd_addr + 1'b1;
      end
      rd_vld <= issue;
    end
  end

  // Draw datapath: sum, row 0 key, wheel remainder, pending result
  always_ff @(posedge clk) begin
    rd_idx <= rd_addr[IDX_W-1:0];
    if (state == wpel_pkg::S_IDLE) begin
      sum <= '0;
    end else if (state == wpel_pkg::S_SUM && eligible) begin
      sum <= sum + SUM_W'(rd_wt);
    end
    if (state == wpel_pkg::S_SUM && rd_vld && rd_idx == '0) begin
      key0 <= rd_key;
    end
    if (in_acc) begin
      rnd <= random_value;
    end
    if (mod_done) begin
      remain <= mod_rem + 1'b1;
    end else if (state == wpel_pkg::S_WALK && eligible && !hit) begin
      remain <= remain - SUM_W'(rd_wt);
    end
    // Stage the result word
    if (in_acc) begin
      res_idx <= '0;
      res_key <= '0;
      if (is_append) begin
        res_status <= is_full ? wpel_pkg::ST_FULL : wpel_pkg::ST_APPENDED;
      end else begin
        res_status <= (count == '0) ? wpel_pkg::ST_EMPTY : wpel_pkg::ST_PICKED;
      end
    end else if (state == wpel_pkg::S_SUM && scan_end && sum == '0) begin
      res_key <= key0;
    end else if (state == wpel_pkg::S_WALK && hit) begin
      res_idx <= rd_idx;
      res_key <= rd_key;
    end else if (state == wpel_pkg::S_WALK && scan_end) begin
      res_idx <= '0;
      res_key <= key0;
    end
  end

  // Output register: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= res_status;
      picked_index <= PW'(res_idx);
      picked_key   <= res_key;
    end
  end

endmodule

`default_nettype wire
